// ===== hdl/clr_pkg.sv =====
package clr_pkg;

    // Controller states
    typedef enum logic [0:0] {
        S_IDLE = 1'b0,
        S_EMIT = 1'b1
    } t_state;

    // Status codes carried on status results
    typedef enum logic [2:0] {
        STAT_OK       = 3'd0,
        STAT_EMPTY    = 3'd1,
        STAT_OVERRUN  = 3'd2,
        STAT_TOO_LONG = 3'd3,
        STAT_RELEASED = 3'd4
    } t_status;

    // Input request kind (tuser)
    localparam logic MODE_BYTE    = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    // Result kind (tuser)
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_BYTE   = 1'b1;

    // Terminator after reset: carriage return
    localparam logic [7:0] TERM_RESET = 8'd13;

    localparam int unsigned OUT_PAD_BITS = 5;

endpackage

// ===== hdl/command_line_receiver_unit.sv =====
// Channel   | Signals                                  | Content
// ----------+------------------------------------------+---------------------------------
// s_axis    | tvalid, tready, tdata[7:0], tuser[0]     | received byte / release request
// m_axis    | tvalid, tready, tdata[15:0], tuser, tlast| status or line byte result
// cfg       | i_cfg_wr_en, i_cfg_wr_data[7:0]          | terminator byte
//
// A byte, release or rejected terminator gives one status result; once the request is
// taken, its result sits in the output register the next cycle.
// An accepted terminator gives N line bytes: the line memory is read through its single
// read port into registered read data, then one byte per cycle while m_axis is ready.
// No new request is taken while a line is being sent; a stalled m_axis holds the
// output register and the memory read data. Reset (i_rst_n low, synchronous) empties
// the line, frees the parse slot and sets the terminator to carriage return.
module command_line_receiver_unit
    import clr_pkg::*;
#(
    parameter int unsigned LINE_BUFFER_BYTES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tuser,   // [0] mode
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [2:0] status_code, [10:3] line_byte, rest zero
    output logic        m_axis_tuser,   // [0] result_kind
    output logic        m_axis_tlast    // last_of_run
);

    localparam int unsigned AW = (LINE_BUFFER_BYTES > 2) ? $clog2(LINE_BUFFER_BYTES) : 1;
    localparam logic [AW-1:0] MAX_FILL = AW'(LINE_BUFFER_BYTES - 1);

    // Line memory and its registered read data
    logic [7:0]    r_line_mem [LINE_BUFFER_BYTES];
    logic [7:0]    r_rd_data;

    // Control state
    t_state        r_state, n_state;
    logic [AW-1:0] r_fill_cnt, n_fill_cnt;
    logic          r_locked, n_locked;
    logic [7:0]    r_term;

    // Line send counters
    logic [AW-1:0] r_emit_idx, n_emit_idx;
    logic [AW-1:0] r_emit_n, n_emit_n;

    // Output register
    logic          r_out_valid, n_out_valid;
    logic          r_out_kind, n_out_kind;
    t_status       r_out_status, n_out_status;
    logic [7:0]    r_out_byte, n_out_byte;
    logic          r_out_last, n_out_last;

    // Memory port controls
    logic          w_wr_en;
    logic [AW-1:0] w_wr_addr;
    logic          w_rd_en;
    logic [AW-1:0] w_rd_addr;

    logic          w_out_free;
    logic          w_in_acc;
    logic          w_is_term;
    logic          w_start;
    logic          w_emit_last;

    assign w_out_free  = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && w_out_free;
    assign w_in_acc    = s_axis_tvalid && s_axis_tready;
    assign w_is_term   = (s_axis_tdata == r_term);
    assign w_start     = w_in_acc && (s_axis_tuser == MODE_BYTE) && w_is_term &&
                         (r_fill_cnt != '0) && !r_locked;
    assign w_emit_last = (r_emit_idx == r_emit_n);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_start) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free && w_emit_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and memory control
    always_comb begin
        n_fill_cnt   = r_fill_cnt;
        n_locked     = r_locked;
        n_emit_idx   = r_emit_idx;
        n_emit_n     = r_emit_n;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_kind   = r_out_kind;
        n_out_status = r_out_status;
        n_out_byte   = r_out_byte;
        n_out_last   = r_out_last;
        w_wr_en      = 1'b0;
        w_wr_addr    = r_fill_cnt;
        w_rd_en      = 1'b0;
        w_rd_addr    = r_emit_idx;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    // default: one status result
                    n_out_valid = 1'b1;
                    n_out_kind  = KIND_STATUS;
                    n_out_byte  = 8'd0;
                    n_out_last  = 1'b1;
                    priority if (s_axis_tuser == MODE_RELEASE) begin
                        n_locked     = 1'b0;
                        n_out_status = STAT_RELEASED;
                    end else if (!w_is_term) begin
                        if (r_fill_cnt == MAX_FILL) begin
                            n_fill_cnt   = '0;
                            n_out_status = STAT_TOO_LONG;
                        end else begin
                            w_wr_en      = 1'b1;
                            n_fill_cnt   = r_fill_cnt + AW'(1);
                            n_out_status = STAT_OK;
                        end
                    end else if (r_fill_cnt == '0) begin
                        n_out_status = STAT_EMPTY;
                    end else if (r_locked) begin
                        n_fill_cnt   = '0;
                        n_out_status = STAT_OVERRUN;
                    end else begin
                        // accept line: lock slot, fetch first byte
                        n_out_valid = 1'b0;
                        n_locked    = 1'b1;
                        n_emit_n    = r_fill_cnt;
                        n_emit_idx  = AW'(1);
                        n_fill_cnt  = '0;
                        w_rd_en     = 1'b1;
                        w_rd_addr   = '0;
                    end
                end
            end
            S_EMIT: begin
                // hand over fetched byte, prefetch the next one
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_kind   = KIND_BYTE;
                    n_out_status = STAT_OK;
                    n_out_byte   = r_rd_data;
                    n_out_last   = w_emit_last;
                    if (!w_emit_last) begin
                        w_rd_en    = 1'b1;
                        n_emit_idx = r_emit_idx + AW'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    // Line memory
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_line_mem[w_wr_addr] <= s_axis_tdata;
        end
        if (w_rd_en) begin
            r_rd_data <= r_line_mem[w_rd_addr];
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill_cnt  <= '0;
            r_locked    <= 1'b0;
            r_out_valid <= 1'b0;
            r_term      <= TERM_RESET;
        end else begin
            r_state     <= n_state;
            r_fill_cnt  <= n_fill_cnt;
            r_locked    <= n_locked;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_term <= i_cfg_wr_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_emit_idx   <= n_emit_idx;
        r_emit_n     <= n_emit_n;
        r_out_kind   <= n_out_kind;
        r_out_status <= n_out_status;
        r_out_byte   <= n_out_byte;
        r_out_last   <= n_out_last;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{OUT_PAD_BITS{1'b0}}, r_out_byte, r_out_status};
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;

    // Checks
    a_no_rw_same_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_rd_en && w_wr_en))
        else $error("line memory read and write in the same cycle");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill_cnt <= MAX_FILL)
        else $error("fill count beyond line capacity");

    a_start_locks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> (r_state == S_EMIT) && r_locked && (r_fill_cnt == '0))
        else $error("accepted line did not lock slot and start sending");

    a_emit_locked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> r_locked)
        else $error("sending a line with the slot free");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EMIT) && w_out_free && w_emit_last) |=>
            (r_state == S_IDLE) && m_axis_tvalid && m_axis_tlast)
        else $error("last line byte did not end the run");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import clr_pkg::*;

    localparam int unsigned LINE_BYTES    = 32;
    localparam int unsigned MAX_FILL      = LINE_BYTES - 1;
    localparam int unsigned SETTLE_CYCLES = 6;
    localparam int unsigned STUCK_LIMIT   = 2000;
    localparam int unsigned MAX_REPORTS   = 30;

    typedef struct {
        logic       kind;
        t_status    status;
        logic [7:0] lbyte;
        logic       last;
    } t_line_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [7:0]  i_cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] rx_byte
    logic        s_axis_tuser;   // [0] mode
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // [2:0] status_code, [10:3] line_byte, [15:11] zero
    logic        m_axis_tuser;   // [0] result_kind
    logic        m_axis_tlast;

    // Line buffer shadow state
    logic [7:0]  line_shadow [LINE_BYTES];
    int unsigned fill_shadow;
    bit          slot_locked;
    logic [7:0]  term_shadow;

    t_line_result expected_results [$];

    int unsigned mismatches;
    int unsigned requests_sent;
    int unsigned results_checked;
    int unsigned lines_emitted;
    int unsigned overruns_seen;
    int unsigned too_long_seen;
    int unsigned stuck_cycles = 0;
    int unsigned hold_len;
    bit          sender_gaps;
    bit          receiver_stalls;

    command_line_receiver_unit #(
        .LINE_BUFFER_BYTES(LINE_BYTES)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void push_status(t_status code);
        t_line_result r;
        r.kind   = KIND_STATUS;
        r.status = code;
        r.lbyte  = 8'd0;
        r.last   = 1'b1;
        expected_results.push_back(r);
    endfunction

    // Line buffer behavior for one accepted request
    function automatic void predict_line_request(logic mode, logic [7:0] data);
        t_line_result r;
        if (mode == MODE_RELEASE) begin
            slot_locked = 1'b0;
            push_status(STAT_RELEASED);
        end else if (data != term_shadow) begin
            if (fill_shadow >= MAX_FILL) begin
                fill_shadow = 0;
                too_long_seen++;
                push_status(STAT_TOO_LONG);
            end else begin
                line_shadow[fill_shadow] = data;
                fill_shadow++;
                push_status(STAT_OK);
            end
        end else if (fill_shadow == 0) begin
            push_status(STAT_EMPTY);
        end else if (slot_locked) begin
            fill_shadow = 0;
            overruns_seen++;
            push_status(STAT_OVERRUN);
        end else begin
            slot_locked = 1'b1;
            for (int unsigned k = 0; k < fill_shadow; k++) begin
                r.kind   = KIND_BYTE;
                r.status = STAT_OK;
                r.lbyte  = line_shadow[k];
                r.last   = (k + 1 == fill_shadow);
                expected_results.push_back(r);
            end
            fill_shadow = 0;
            lines_emitted++;
        end
    endfunction

    function automatic logic [7:0] ordinary_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == term_shadow);
        return b;
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        if (mismatches < MAX_REPORTS)
            $display("[%0t] mismatch %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    // Offer one request and hold it until accepted; random gap afterwards
    task automatic send_req(logic mode, logic [7:0] data);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= mode;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_line_request(mode, data);
        requests_sent++;
        if (sender_gaps && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic send_byte(logic [7:0] data);
        send_req(MODE_BYTE, data);
    endtask

    task automatic send_release();
        send_req(MODE_RELEASE, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_line(int unsigned len);
        for (int unsigned i = 0; i < len; i++) send_byte(ordinary_byte());
        send_byte(term_shadow);
    endtask

    // Stop offering and wait until every expected result has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_terminator(logic [7:0] value);
        drain();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        term_shadow = value;
    endtask

    // Status codes, extreme bytes, overrun and double release
    task automatic test_directed_cases();
        send_release();
        send_byte(term_shadow);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(term_shadow);
        send_byte(8'h5A);
        send_byte(term_shadow);
        send_byte(term_shadow);
        send_release();
        send_release();
        send_byte(8'h80);
        send_byte(8'h7F);
        send_byte(term_shadow);
        send_req(MODE_RELEASE, 8'hFF);
        send_req(MODE_RELEASE, 8'h00);
    endtask

    // Terminator at both ends of the byte range; carriage return as plain data
    task automatic test_terminator_values();
        write_terminator(8'h00);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_release();
        write_terminator(8'hFF);
        send_byte(8'h00);
        send_byte(TERM_RESET);
        send_byte(8'hFF);
        send_release();
        write_terminator(TERM_RESET);
    endtask

    // Longest accepted line, then an overlong one that gets dropped
    task automatic test_line_length();
        send_line(MAX_FILL);
        send_release();
        for (int unsigned i = 0; i < MAX_FILL + 1; i++) send_byte(ordinary_byte());
        send_byte(term_shadow);
        send_line(3);
        send_release();
    endtask

    // Receiver holds off long enough for the block to stall its input
    task automatic test_backpressure();
        drain();
        hold_len = 80;
        for (int i = 0; i < 3; i++) begin
            send_line(4);
            send_release();
        end
        drain();
    endtask

    // Mostly well-formed lines with random content, plus noise
    task automatic test_random_traffic(int unsigned n_items);
        int unsigned target;
        int unsigned pick;
        int unsigned len;
        target = requests_sent + n_items;
        while (requests_sent < target) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                len = ($urandom_range(0, 11) == 0) ? $urandom_range(25, 33)
                                                  : $urandom_range(1, 6);
                for (int unsigned i = 0; i < len; i++) begin
                    if ($urandom_range(0, 19) == 0) send_byte(8'($urandom_range(0, 255)));
                    else send_byte(ordinary_byte());
                end
                send_byte(term_shadow);
                if ($urandom_range(0, 3) != 0) send_release();
            end else if (pick == 7) begin
                send_req(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            end else if (pick == 8) begin
                send_byte(term_shadow);
            end else begin
                send_release();
            end
        end
    endtask

    // Main sequence
    initial begin
        i_rst_n         = 1'b0;
        i_cfg_wr_en     = 1'b0;
        i_cfg_wr_data   = 8'd0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = 8'd0;
        s_axis_tuser    = MODE_BYTE;
        m_axis_tready   = 1'b1;
        fill_shadow     = 0;
        slot_locked     = 1'b0;
        term_shadow     = TERM_RESET;
        mismatches      = 0;
        requests_sent   = 0;
        results_checked = 0;
        lines_emitted   = 0;
        overruns_seen   = 0;
        too_long_seen   = 0;
        hold_len        = 0;
        sender_gaps     = 1'b1;
        receiver_stalls = 1'b1;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_terminator_values();
        test_line_length();
        test_backpressure();
        test_random_traffic(25);
        write_terminator(8'($urandom_range(0, 255)));
        test_random_traffic(20);
        write_terminator(TERM_RESET);
        sender_gaps     = 1'b0;
        receiver_stalls = 1'b0;
        test_random_traffic(15);
        drain();
        repeat (10) @(posedge i_clk);

        $display("Sent %0d requests, checked %0d results: %0d lines emitted,",
                 requests_sent, results_checked, lines_emitted);
        $display("%0d overruns, %0d overlong lines, terminators 0x0D/0x00/0xFF/random",
                 overruns_seen, too_long_seen);
        if (mismatches == 0) begin
            $display("** command_line_receiver_unit: PASSED **");
        end else begin
            $display("** command_line_receiver_unit: FAILED **");
        end
        $finish;
    end

    // Result side ready: random short stalls and one long hold-off
    initial begin
        int unsigned n;
        forever begin
            @(posedge i_clk);
            if (hold_len != 0) begin
                n = hold_len;
                hold_len = 0;
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end else if (receiver_stalls && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_line_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", m_axis_tdata, 16'd0);
            end else begin
                want = expected_results.pop_front();
                if (m_axis_tuser !== want.kind)
                    report_mismatch("result_kind", 16'(m_axis_tuser), 16'(want.kind));
                if (m_axis_tdata[2:0] !== want.status)
                    report_mismatch("status_code", 16'(m_axis_tdata[2:0]), 16'(want.status));
                if (m_axis_tdata[10:3] !== want.lbyte)
                    report_mismatch("line_byte", 16'(m_axis_tdata[10:3]), 16'(want.lbyte));
                if (m_axis_tdata[15:11] !== 5'd0)
                    report_mismatch("tdata padding", 16'(m_axis_tdata[15:11]), 16'd0);
                if (m_axis_tlast !== want.last)
                    report_mismatch("last_of_run", 16'(m_axis_tlast), 16'(want.last));
            end
            results_checked++;
        end
    end

    // Watchdog: too long without any request or result moving
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("[%0t] timeout with %0d results outstanding",
                     $time, expected_results.size());
            $display("** command_line_receiver_unit: FAILED **");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

endmodule

// ===== files.f =====
hdl/clr_pkg.sv
hdl/command_line_receiver_unit.sv
test/tb_top.sv
